[sv/sttbl_pkg.sv]
// Package with word types, operation codes and status codes of the set table.
`default_nettype none

package sttbl_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int ELEM_W = 32;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [ELEM_W-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic               success;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd_last;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rm_hit;
  } dp_sts_t;

endpackage

`default_nettype wire

[sv/sttbl_dp.sv]
// Datapath of the set table: entry memory, count, scan pointers and result register.
`default_nettype none

module sttbl_dp
  import sttbl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  ctl_cmd_t   cmd,
  input  in_word_t   in_word,
  output dp_sts_t    sts,
  output out_word_t  out_word,
  output logic       out_strobe
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [ELEM_W-1:0] mem [CAPACITY];
  logic [ELEM_W-1:0] rdata_r;

  logic [1:0]        op_r;
  logic [ELEM_W-1:0] elem_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]     cmp_ptr_r, cmp_ptr_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              hit_r, hit_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  out_word_t         out_r, out_nxt;
  logic              strobe_r;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [CW-1:0]     cnt_m1;
  logic              issue;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign cnt_m1 = cnt_r - CW'(1);
  assign issue  = cmd.scan && !hit_r && (rd_ptr_r < cnt_r);
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = rd_ptr_r[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = slot_r;
    wr_data     = rdata_r;
    cnt_nxt     = cnt_r;
    rd_ptr_nxt  = rd_ptr_r;
    cmp_ptr_nxt = cmp_ptr_r;
    cmp_vld_nxt = cmp_vld_r;
    hit_nxt     = hit_r;
    slot_nxt    = slot_r;
    out_nxt     = out_r;

    if (cmd.load) begin
      rd_ptr_nxt  = '0;
      cmp_vld_nxt = 1'b0;
      hit_nxt     = 1'b0;
    end

    if (cmd.scan) begin
      if (cmp_vld_r && !hit_r && (rdata_r == elem_r)) begin
        hit_nxt  = 1'b1;
        slot_nxt = cmp_ptr_r;
      end
      cmp_vld_nxt = issue;
      if (issue) begin
        rd_en       = 1'b1;
        rd_addr     = rd_ptr_r[AW-1:0];
        cmp_ptr_nxt = rd_ptr_r[AW-1:0];
        rd_ptr_nxt  = rd_ptr_r + CW'(1);
      end
    end

    if (cmd.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = cnt_m1[AW-1:0];
    end

    if (cmd.commit) begin
      out_nxt.success = 1'b0;
      out_nxt.status  = ST_DONE;
      case (op_r)
        OP_ADD: begin
          if (hit_r) begin
            out_nxt.status = ST_PRESENT;
          end else if (cnt_r == CW'(CAPACITY)) begin
            out_nxt.status = ST_FULL;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = cnt_r[AW-1:0];
            wr_data         = elem_r;
            cnt_nxt         = cnt_r + CW'(1);
            out_nxt.success = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!hit_r) begin
            out_nxt.status = ST_NOTFOUND;
          end else begin
            wr_en           = 1'b1;
            wr_addr         = slot_r;
            wr_data         = rdata_r;
            cnt_nxt         = cnt_m1;
            out_nxt.success = 1'b1;
          end
        end
        default: begin
          if (hit_r) begin
            out_nxt.success = 1'b1;
          end else begin
            out_nxt.status = ST_NOTFOUND;
          end
        end
      endcase
      out_nxt.count     = cnt_ext[COUNT_W-1:0];
      out_nxt.empty_res = (cnt_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_word.opcode;
      elem_r <= in_word.element;
    end
    cmp_ptr_r <= cmp_ptr_nxt;
    slot_r    <= slot_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_ptr_r  <= '0;
      cmp_vld_r <= 1'b0;
      hit_r     <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      hit_r     <= hit_nxt;
      strobe_r  <= cmd.commit;
    end
  end

  assign sts.scan_done = hit_r || (!cmp_vld_r && (rd_ptr_r >= cnt_r));
  assign sts.rm_hit    = hit_r && (op_r == OP_REMOVE);
  assign out_word      = out_r;
  assign out_strobe    = strobe_r;

endmodule

`default_nettype wire

[sv/sttbl_ctrl.sv]
// Controller of the set table: sequences load, scan, last-entry read and commit.
`default_nettype none

module sttbl_ctrl
  import sttbl_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       start,
  input  dp_sts_t   sts,
  output ctl_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.rd_last = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.rm_hit ? S_LAST : S_COMMIT;
        end
      end
      S_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

[sv/set_table_insert_remove_lookup_top.sv]
// Top level of the set table: controller, datapath and checks.
//
//   channel  ports                          accepted when
//   input    start, busy, in_word           start high and busy low at a clock edge
//   result   out_strobe, out_word           out_strobe high at a clock edge
//
// An operation scans the stored entries one memory read per cycle and then
// commits its result, which is marked by the result strobe.
// A remove that finds its element also reads the last entry, which then fills the freed slot.
// Reset is synchronous and active low; it empties the table without touching memory.
// The receiver cannot stall; out_strobe marks each result word for exactly one cycle.
`default_nettype none

module set_table_insert_remove_lookup_top
  import sttbl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  in_word_t   in_word,
  output out_word_t  out_word,
  output logic       out_strobe
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  sttbl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  sttbl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .sts        (sts),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.success) |-> (out_word.status == ST_DONE))
    else $error("success with a failure status");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.empty_res) |-> (out_word.count == '0))
    else $error("empty flag with nonzero count");

endmodule

`default_nettype wire
